// ===== rtl/core/ledfade_pkg.sv =====
// ----------------------------------------------------------------------------
// ledfade_pkg
// types and constants shared by the led fade ramp controller
// ----------------------------------------------------------------------------
package ledfade_pkg;

  localparam int DUTY_W  = 7;
  localparam int PWM_W   = 10;
  localparam int TIME_W  = 16;
  localparam int LEVEL_W = 8;
  localparam int ACT_W   = 3;

  localparam logic [DUTY_W-1:0] LOWER_LIMIT_RST = 7'd5;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK = 3'd0,
    ACT_SET  = 3'd1,
    ACT_UP   = 3'd2,
    ACT_DOWN = 3'd3,
    ACT_ON   = 3'd4,
    ACT_OFF  = 3'd5,
    ACT_MOVE = 3'd6
  } action_t;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } fsm_t;

  typedef struct packed {
    logic [ACT_W-1:0]          action;
    logic signed [LEVEL_W-1:0] level;
    logic [TIME_W-1:0]         ramp_time_ms;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic [PWM_W-1:0]  pwm_level;
    logic              moving;
    logic              lit;
    logic              ramp_up;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// ===== rtl/core/ledfade_div.sv =====
// ----------------------------------------------------------------------------
// ledfade_div
// restoring divider, one quotient bit per cycle, for the step period
// ----------------------------------------------------------------------------
module ledfade_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ledfade_pkg::TIME_W-1:0] dividend,
  input  logic [ledfade_pkg::DUTY_W-1:0] divisor,
  output logic [ledfade_pkg::TIME_W-1:0] quotient,
  output ledfade_pkg::div_sts_t          sts
);
  import ledfade_pkg::*;

  localparam int CNT_W = $clog2(TIME_W);

  logic [TIME_W-1:0] work;
  logic [DUTY_W-1:0] dsr;
  logic [DUTY_W-1:0] rem;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;

  logic [DUTY_W:0]   rem_sh;
  logic [DUTY_W:0]   rem_sub;
  logic              fits;

  always_comb begin
    rem_sh  = {rem, work[TIME_W-1]};
    rem_sub = rem_sh - {1'b0, dsr};
    fits    = rem_sh >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(TIME_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      dsr  <= divisor;
      rem  <= '0;
    end else if (busy) begin
      work <= {work[TIME_W-2:0], fits};
      rem  <= fits ? rem_sub[DUTY_W-1:0] : rem_sh[DUTY_W-1:0];
    end
  end

  assign quotient  = work;
  assign sts.busy  = busy;
  assign sts.done  = done;

endmodule

// ===== rtl/core/led_dimmer_fade_ramp.sv =====
// ----------------------------------------------------------------------------
// led_dimmer_fade_ramp
// led duty controller with timed fade ramp toward a goal duty
// ----------------------------------------------------------------------------
// channel  dir  handshake              payload
// in       in   in_valid / in_ready    in_item   (action, level, ramp_time_ms)
// out      out  out_valid / out_ready  out_item  (duty, pwm_level, moving, lit, ramp_up)
// cfg      in   cfg_valid / cfg_ready  cfg_data  (lower_limit)
//
// tick, set, up, down and equal-goal moves: result registered, valid in the cycle after the item
// a move that starts a ramp: result once the 16-step divider is done
// in_ready drops while the divider runs; cfg_ready is always high
// a result held by out_ready low blocks the next item
// reset: lower_limit 5, other control state zero, out_item not reset, no clearing pass
// ----------------------------------------------------------------------------
module led_dimmer_fade_ramp #(
  parameter int FULL_DUTY = 100,
  parameter int PWM_SCALE = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ledfade_pkg::in_item_t           in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ledfade_pkg::out_item_t          out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ledfade_pkg::DUTY_W-1:0]  cfg_data
);
  import ledfade_pkg::*;

  localparam logic [DUTY_W-1:0]  FULL = DUTY_W'(FULL_DUTY);
  localparam logic [LEVEL_W-1:0] FULL_LVL = LEVEL_W'(FULL_DUTY);
  localparam logic [PWM_W-1:0]   SCALE = PWM_W'(PWM_SCALE);

  fsm_t state, state_next;

  logic [DUTY_W-1:0] lower_limit;
  logic [DUTY_W-1:0] current_duty, current_duty_next;
  logic [DUTY_W-1:0] goal_duty, goal_duty_next;
  logic [DUTY_W-1:0] remembered_duty, remembered_duty_next;
  logic              going_up, going_up_next;
  logic [TIME_W-1:0] step_period, step_period_next;
  logic [TIME_W-1:0] tick_count, tick_count_next;
  logic              ramp_active, ramp_active_next;

  logic              accept;
  logic              load_out;
  logic              div_start;
  logic [TIME_W-1:0] quotient;
  div_sts_t          div_sts;

  logic [DUTY_W-1:0] clamped;
  logic [DUTY_W-1:0] mv_goal;
  logic [DUTY_W-1:0] snapped;
  logic              is_move;
  logic              mv_up;
  logic [DUTY_W-1:0] distance;
  logic [TIME_W-1:0] tick_inc;
  logic [DUTY_W-1:0] stepped;
  logic [PWM_W-1:0]  pwm_next;

  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  ledfade_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (in_item.ramp_time_ms),
    .divisor  (distance),
    .quotient (quotient),
    .sts      (div_sts)
  );

  // move goal selection
  always_comb begin
    if (in_item.level[LEVEL_W-1]) begin
      clamped = '0;
    end else if (in_item.level >= FULL_LVL) begin
      clamped = FULL;
    end else begin
      clamped = in_item.level[DUTY_W-1:0];
    end
    case (in_item.action)
      ACT_ON:  mv_goal = (remembered_duty <= lower_limit) ? FULL : remembered_duty;
      ACT_OFF: mv_goal = '0;
      default: mv_goal = clamped;
    endcase
    snapped  = (mv_goal <= lower_limit) ? '0 : mv_goal;
    is_move  = (in_item.action == ACT_ON) || (in_item.action == ACT_OFF) ||
               (in_item.action == ACT_MOVE);
    mv_up    = snapped > current_duty;
    distance = mv_up ? (snapped - current_duty) : (current_duty - snapped);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (div_start) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_sts.done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = !out_valid || out_ready;
      ST_DIV:  in_ready = 1'b0;
      default: in_ready = 1'b0;
    endcase
    div_start = accept && is_move && (snapped != current_duty);
    load_out  = (accept && !div_start) || ((state == ST_DIV) && div_sts.done);
  end

  // datapath
  always_comb begin
    current_duty_next    = current_duty;
    goal_duty_next       = goal_duty;
    remembered_duty_next = remembered_duty;
    going_up_next        = going_up;
    step_period_next     = step_period;
    tick_count_next      = tick_count;
    ramp_active_next     = ramp_active;
    tick_inc             = tick_count + 1'b1;
    if (current_duty < goal_duty) begin
      stepped = current_duty + 1'b1;
    end else if (current_duty > goal_duty) begin
      stepped = current_duty - 1'b1;
    end else begin
      stepped = current_duty;
    end

    if (accept) begin
      case (in_item.action)
        ACT_TICK: begin
          if (ramp_active) begin
            if (tick_inc < step_period) begin
              tick_count_next = tick_inc;
            end else begin
              tick_count_next   = '0;
              current_duty_next = stepped;
              if (stepped == goal_duty) ramp_active_next = 1'b0;
            end
          end
        end
        ACT_SET: current_duty_next = clamped;
        ACT_UP: begin
          if (current_duty < FULL) current_duty_next = current_duty + 1'b1;
        end
        ACT_DOWN: begin
          if (current_duty != '0) current_duty_next = current_duty - 1'b1;
        end
        ACT_ON, ACT_OFF, ACT_MOVE: begin
          if (in_item.action == ACT_OFF) remembered_duty_next = current_duty;
          goal_duty_next = snapped;
          if (snapped == current_duty) begin
            ramp_active_next = 1'b0;
          end else begin
            going_up_next    = mv_up;
            tick_count_next  = '0;
            ramp_active_next = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if ((state == ST_DIV) && div_sts.done) begin
      step_period_next = (quotient == '0) ? TIME_W'(1) : quotient;
    end

    pwm_next = PWM_W'(current_duty_next) * SCALE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      lower_limit     <= LOWER_LIMIT_RST;
      current_duty    <= '0;
      goal_duty       <= '0;
      remembered_duty <= '0;
      going_up        <= 1'b0;
      step_period     <= '0;
      tick_count      <= '0;
      ramp_active     <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state           <= state_next;
      current_duty    <= current_duty_next;
      goal_duty       <= goal_duty_next;
      remembered_duty <= remembered_duty_next;
      going_up        <= going_up_next;
      step_period     <= step_period_next;
      tick_count      <= tick_count_next;
      ramp_active     <= ramp_active_next;
      if (cfg_valid && cfg_ready) lower_limit <= cfg_data;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item.duty      <= current_duty_next;
      out_item.pwm_level <= pwm_next;
      out_item.moving    <= ramp_active_next;
      out_item.lit       <= current_duty_next > lower_limit;
      out_item.ramp_up   <= going_up_next;
    end
  end

endmodule

// ===== rtl/core/ledfade_checker.sv =====
// ----------------------------------------------------------------------------
// ledfade_checker
// port-level checks for the led fade ramp controller
// ----------------------------------------------------------------------------
module ledfade_checker #(
  parameter int FULL_DUTY = 100,
  parameter int PWM_SCALE = 10
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input ledfade_pkg::in_item_t  in_item,
  input logic                   out_valid,
  input logic                   out_ready,
  input ledfade_pkg::out_item_t out_item
);
  import ledfade_pkg::*;

  localparam logic [DUTY_W-1:0]  FULL = DUTY_W'(FULL_DUTY);
  localparam logic [LEVEL_W-1:0] FULL_LVL = LEVEL_W'(FULL_DUTY);
  localparam logic [PWM_W-1:0]   SCALE = PWM_W'(PWM_SCALE);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.duty <= FULL)
    else $error("duty above full scale");

  a_pwm_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.pwm_level == PWM_W'(PWM_W'(out_item.duty) * SCALE))
    else $error("pwm level does not follow duty");

  a_set_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_item.action == ACT_SET && !in_item.level[LEVEL_W-1] &&
    in_item.level < FULL_LVL
    |=> out_valid && out_item.duty == $past(in_item.level[DUTY_W-1:0]))
    else $error("set item not reflected in next result");

endmodule

bind led_dimmer_fade_ramp ledfade_checker #(
  .FULL_DUTY (FULL_DUTY),
  .PWM_SCALE (PWM_SCALE)
) u_ledfade_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
